// ===== rtl/mll_pkg.sv =====
// shared types and constants for the multinomial log-likelihood block
`timescale 1ns / 1ps

package mll_pkg;

	localparam int COUNT_W   = 10;
	localparam int LP_W      = 23;
	localparam int OUT_W     = 35;
	localparam int NUM_CAT   = 4;
	localparam int CAT_W     = 3;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = LP_W;
	localparam int TOT_W     = COUNT_W + 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LOG_PROB_A      = 3'd0,
		REG_LOG_PROB_B      = 3'd1,
		REG_LOG_PROB_C      = 3'd2,
		REG_LOG_PROB_D      = 3'd3,
		REG_CATEGORY_COUNT  = 3'd4,
		REG_WITH_COEFFICIENT = 3'd5
	} cfg_reg_e;

	typedef struct packed {
		logic [NUM_CAT-1:0][LP_W-1:0] log_prob;
		logic [CAT_W-1:0]             category_count;
		logic                         with_coefficient;
	} cfg_t;

endpackage

// ===== rtl/mll_ifs.sv =====
// handshake channels of the multinomial log-likelihood block
`timescale 1ns / 1ps

interface mll_in_if;
	import mll_pkg::*;
	logic               valid;
	logic               ready;
	logic [COUNT_W-1:0] count_a;
	logic [COUNT_W-1:0] count_b;
	logic [COUNT_W-1:0] count_c;
	logic [COUNT_W-1:0] count_d;

	modport source (output valid, count_a, count_b, count_c, count_d, input ready);
	modport sink (input valid, count_a, count_b, count_c, count_d, output ready);
endinterface

interface mll_out_if;
	import mll_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] log_likelihood;
	logic                    unsupported_size;

	modport source (output valid, log_likelihood, unsupported_size, input ready);
	modport sink (input valid, log_likelihood, unsupported_size, output ready);
endinterface

interface mll_cfg_if;
	import mll_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/mll_cfg.sv =====
// configuration register file
`timescale 1ns / 1ps

module mll_cfg import mll_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	mll_cfg_if.sink   cfg,
	output cfg_t      regs
);

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.log_prob         <= '0;
			regs_q.category_count   <= CAT_W'(4);
			regs_q.with_coefficient <= 1'b1;
		end else if (cfg.valid) begin
			case (cfg_reg_e'(cfg.index))
				REG_LOG_PROB_A:       regs_q.log_prob[0] <= cfg.data[LP_W-1:0];
				REG_LOG_PROB_B:       regs_q.log_prob[1] <= cfg.data[LP_W-1:0];
				REG_LOG_PROB_C:       regs_q.log_prob[2] <= cfg.data[LP_W-1:0];
				REG_LOG_PROB_D:       regs_q.log_prob[3] <= cfg.data[LP_W-1:0];
				REG_CATEGORY_COUNT:   regs_q.category_count <= cfg.data[CAT_W-1:0];
				REG_WITH_COEFFICIENT: regs_q.with_coefficient <= cfg.data[0];
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/mll_lf_rom.sv =====
// log-factorial rom with registered read ports
`timescale 1ns / 1ps

module mll_lf_rom import mll_pkg::*; #(
	parameter int TABLE_DEPTH = 4096,
	parameter int FRAC_BITS   = 16,
	parameter int RD_PORTS    = 2,
	parameter int AW          = $clog2(TABLE_DEPTH),
	parameter int LF_W        = FRAC_BITS + AW + $clog2(AW + 1)
) (
	input  logic                           clk,
	input  logic                           rd_en,
	input  logic [RD_PORTS-1:0][AW-1:0]    rd_addr,
	output logic [RD_PORTS-1:0][LF_W-1:0]  rd_data
);

	localparam int LN_FRAC     = 44;
	localparam int ATANH_TERMS = 16;

	logic [LF_W-1:0] lf_mem [TABLE_DEPTH];

	// restoring long division
	function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] rem;
		logic [63:0] quo;
		rem = '0;
		quo = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], n[i]};
			if (rem >= d) begin
				rem    = rem - d;
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] ah, al, bh, bl, hi, mid, lo;
		ah  = a >> 32;
		al  = {32'd0, a[31:0]};
		bh  = b >> 32;
		bl  = {32'd0, b[31:0]};
		hi  = ah * bh;
		mid = ah * bl + al * bh;
		lo  = al * bl;
		return (hi << (64 - LN_FRAC)) + ((mid + (lo >> 32)) >> (LN_FRAC - 32));
	endfunction

	function automatic logic [63:0] two_atanh(input logic [63:0] p, input logic [63:0] q);
		logic [63:0] z, z2, term, sum;
		z    = udiv(p << LN_FRAC, q);
		z2   = qmul(z, z);
		term = z;
		sum  = '0;
		for (int j = 0; j < ATANH_TERMS; j++) begin
			sum  = sum + udiv(term, 64'(2 * j + 1));
			term = qmul(term, z2);
		end
		return sum << 1;
	endfunction

	// table content is fixed at power-up
	initial begin : fill_table
		logic [63:0] ln2q, acc_int, acc_frac, fmask, half, lnk, p2, k64;
		int          e;
		ln2q     = two_atanh(64'd1, 64'd3);
		acc_int  = '0;
		acc_frac = '0;
		fmask    = (64'd1 << LN_FRAC) - 64'd1;
		half     = 64'd1 << (LN_FRAC - FRAC_BITS - 1);
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			if (k < 2) begin
				lf_mem[k] = '0;
			end else begin
				k64 = 64'(k);
				e   = 0;
				for (int b = 1; b <= AW; b++) begin
					if ((k64 >> b) != 64'd0)
						e = b;
				end
				p2        = 64'd1 << e;
				lnk       = 64'(e) * ln2q + two_atanh(k64 - p2, k64 + p2);
				acc_frac  = acc_frac + lnk;
				acc_int   = acc_int + (acc_frac >> LN_FRAC);
				acc_frac  = acc_frac & fmask;
				lf_mem[k] = LF_W'((acc_int << FRAC_BITS)
					+ ((acc_frac + half) >> (LN_FRAC - FRAC_BITS)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			for (int p = 0; p < RD_PORTS; p++)
				rd_data[p] <= lf_mem[rd_addr[p]];
		end
	end

endmodule

// ===== rtl/multinomial_log_likelihood.sv =====
// top level of the multinomial log-likelihood block
`timescale 1ns / 1ps

// Computes the multinomial log-probability of one tuple of up to four counts.
// counts: input channel, one count tuple per transfer.
// result: output channel, log_likelihood (Q18.16, saturating) and the
//   unsupported_size flag, one result per input transfer, in order.
// cfg: register write channel, always ready; write only while the block is
//   idle. Index 0..3 log probabilities, 4 category count, 5 coefficient mode.
// Throughput: one tuple per cycle while result is taken. A tuple passes
//   through the rom read and two add stages to the output register.
// The log-factorial table is a constant rom replicated over three instances
//   so that the total and the four counts are looked up in the same cycle.
// Reset: pipeline empties, log probabilities clear to zero, category count
//   goes to 4 and coefficient mode to on. The rom needs no load time.
// Stall: when result is not taken, the output register holds; each stage
//   still fills while the stage after it is empty, so up to three tuples
//   are taken before counts.ready drops.

module multinomial_log_likelihood import mll_pkg::*; #(
	parameter int MAX_COUNT   = 1023,
	parameter int CATEGORIES  = 4,
	parameter int FRAC_BITS   = 16,
	parameter int TABLE_DEPTH = 4096
) (
	input  logic       clk,
	input  logic       arst_n,
	mll_cfg_if.sink    cfg,
	mll_in_if.sink     counts,
	mll_out_if.source  result
);

	localparam int AW      = $clog2(TABLE_DEPTH);
	localparam int LF_W    = FRAC_BITS + AW + $clog2(AW + 1);
	localparam int MCW     = (COUNT_W > $clog2(MAX_COUNT + 1)) ? COUNT_W
		: $clog2(MAX_COUNT + 1);
	localparam int CW      = ((TOT_W > AW) ? TOT_W : AW) + 1;
	localparam int PROD_W  = LP_W + COUNT_W + 1;
	localparam int PS_W    = PROD_W + 2;
	localparam int CF_W    = LF_W + 3;
	localparam int ACC_W   = ((PS_W > CF_W) ? PS_W : CF_W) + 1;
	localparam int FLOOR_I = -(64 << FRAC_BITS);
	localparam logic [CAT_W-1:0] CAT_MAX = CAT_W'(CATEGORIES);
	localparam logic [CAT_W-1:0] CAT_MIN = CAT_W'(2);

	function automatic logic [AW-1:0] sat_addr(input logic [CW-1:0] v);
		if (v > CW'(TABLE_DEPTH - 1))
			return AW'(TABLE_DEPTH - 1);
		return v[AW-1:0];
	endfunction

	cfg_t cfg_q;

	mll_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (cfg_q)
	);

	// stage 0: clamp, lookup addresses, products
	logic [NUM_CAT-1:0][COUNT_W-1:0] cnt_raw, cnt_c;
	logic [NUM_CAT-1:0]              mask;
	logic [CAT_W-1:0]                used;
	logic [TOT_W-1:0]                total;
	logic signed [PROD_W-1:0]        prod [NUM_CAT];
	logic signed [LP_W-1:0]          lp_c [NUM_CAT];
	logic [4:0][AW-1:0]              addr;
	logic                            unsup, add_coef;
	logic en1, en2, en3;

	assign cnt_raw[0] = counts.count_a;
	assign cnt_raw[1] = counts.count_b;
	assign cnt_raw[2] = counts.count_c;
	assign cnt_raw[3] = counts.count_d;

	always_comb begin
		used     = (cfg_q.category_count > CAT_MAX) ? CAT_MAX : cfg_q.category_count;
		unsup    = cfg_q.with_coefficient
			&& (cfg_q.category_count < CAT_MIN || cfg_q.category_count > CAT_MAX);
		add_coef = cfg_q.with_coefficient && !unsup;
		total    = '0;
		for (int i = 0; i < NUM_CAT; i++) begin
			mask[i]  = CAT_W'(i) < used;
			cnt_c[i] = (MCW'(cnt_raw[i]) > MCW'(MAX_COUNT)) ? COUNT_W'(MAX_COUNT)
				: cnt_raw[i];
			if (mask[i])
				total = total + TOT_W'(cnt_c[i]);
			lp_c[i] = $signed(cfg_q.log_prob[i]);
			if (32'(lp_c[i]) < FLOOR_I)
				lp_c[i] = LP_W'(FLOOR_I);
			prod[i]     = $signed({1'b0, cnt_c[i]}) * lp_c[i];
			addr[i + 1] = sat_addr(CW'(cnt_c[i]));
		end
		addr[0] = sat_addr(CW'(total));
	end

	// rom lookups land in stage 1
	logic [1:0][LF_W-1:0] rom_a_q, rom_b_q;
	logic [0:0][LF_W-1:0] rom_c_q;

	mll_lf_rom #(.TABLE_DEPTH(TABLE_DEPTH), .FRAC_BITS(FRAC_BITS), .RD_PORTS(2),
		.AW(AW), .LF_W(LF_W)) u_rom_a (
		.clk     (clk),
		.rd_en   (en1),
		.rd_addr ({addr[1], addr[0]}),
		.rd_data (rom_a_q)
	);

	mll_lf_rom #(.TABLE_DEPTH(TABLE_DEPTH), .FRAC_BITS(FRAC_BITS), .RD_PORTS(2),
		.AW(AW), .LF_W(LF_W)) u_rom_b (
		.clk     (clk),
		.rd_en   (en1),
		.rd_addr ({addr[3], addr[2]}),
		.rd_data (rom_b_q)
	);

	mll_lf_rom #(.TABLE_DEPTH(TABLE_DEPTH), .FRAC_BITS(FRAC_BITS), .RD_PORTS(1),
		.AW(AW), .LF_W(LF_W)) u_rom_c (
		.clk     (clk),
		.rd_en   (en1),
		.rd_addr (addr[4]),
		.rd_data (rom_c_q)
	);

	// pipeline control
	logic v_s1, v_s2, v_s3;

	assign en3          = !v_s3 || result.ready;
	assign en2          = !v_s2 || en3;
	assign en1          = !v_s1 || en2;
	assign counts.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1)
				v_s1 <= counts.valid;
			if (en2)
				v_s2 <= v_s1;
			if (en3)
				v_s3 <= v_s2;
		end
	end

	// stage 1
	logic signed [PROD_W-1:0] prod_s1 [NUM_CAT];
	logic [NUM_CAT-1:0]       mask_s1;
	logic                     add_coef_s1, unsup_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int i = 0; i < NUM_CAT; i++)
				prod_s1[i] <= mask[i] ? prod[i] : '0;
			mask_s1     <= mask;
			add_coef_s1 <= add_coef;
			unsup_s1    <= unsup;
		end
	end

	// stage 2: product sum and coefficient
	logic [NUM_CAT-1:0][LF_W-1:0] lf_cnt;
	logic signed [PS_W-1:0]       psum;
	logic signed [CF_W-1:0]       coef;
	logic signed [PS_W-1:0]       psum_s2;
	logic signed [CF_W-1:0]       coef_s2;
	logic                         unsup_s2;

	assign lf_cnt = {rom_c_q[0], rom_b_q[1], rom_b_q[0], rom_a_q[1]};

	always_comb begin
		psum = '0;
		coef = $signed(CF_W'(rom_a_q[0]));
		for (int i = 0; i < NUM_CAT; i++) begin
			psum = psum + PS_W'(prod_s1[i]);
			if (mask_s1[i])
				coef = coef - $signed(CF_W'(lf_cnt[i]));
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			psum_s2  <= psum;
			coef_s2  <= add_coef_s1 ? coef : '0;
			unsup_s2 <= unsup_s1;
		end
	end

	// stage 3: final add and saturation into the output register
	logic signed [ACC_W-1:0] acc;
	logic signed [OUT_W-1:0] acc_sat;
	logic signed [OUT_W-1:0] log_likelihood_s3;
	logic                    unsupported_size_s3;

	always_comb begin
		acc = ACC_W'(psum_s2) + ACC_W'(coef_s2);
		if ((&acc[ACC_W-1:OUT_W-1]) || !(|acc[ACC_W-1:OUT_W-1]))
			acc_sat = acc[OUT_W-1:0];
		else if (acc[ACC_W-1])
			acc_sat = {1'b1, {(OUT_W - 1){1'b0}}};
		else
			acc_sat = {1'b0, {(OUT_W - 1){1'b1}}};
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			log_likelihood_s3   <= unsup_s2 ? '0 : acc_sat;
			unsupported_size_s3 <= unsup_s2;
		end
	end

	assign result.valid            = v_s3;
	assign result.log_likelihood   = log_likelihood_s3;
	assign result.unsupported_size = unsupported_size_s3;

	// checks
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.unsupported_size |-> result.log_likelihood == '0)
		else $error("flagged result is not zero");

	a_ready_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!counts.ready |-> v_s1 && v_s2 && result.valid && !result.ready)
		else $error("input stalled with room in the pipeline");

	a_flag_needs_coef: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && unsup_s2 |-> cfg_q.with_coefficient)
		else $error("size flag raised without coefficient mode");

endmodule
